@@ src/deq_pkg.sv @@
// ----------------------------------------------------------------------------
// Double-ended queue package
// Command and status codes, default depth and controller/datapath links.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int unsigned DEPTH_DEF = 16;

  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_REVERSE    = 3'd4;
  localparam logic [2:0] CMD_DUMP_FWD   = 3'd5;
  localparam logic [2:0] CMD_DUMP_BWD   = 3'd6;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic accept;
    logic exec;
    logic load;
  } deq_cmd_t;

  typedef struct packed {
    logic out_free;
    logic dump_more;
  } deq_stat_t;

endpackage

@@ src/deq_ctrl.sv @@
// ----------------------------------------------------------------------------
// Double-ended queue controller
// Sequences accept, execute and result beats for one command at a time.
// ----------------------------------------------------------------------------
module deq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  deq_pkg::deq_stat_t  stat_i,
  output deq_pkg::deq_cmd_t   ctrl_o
);
  import deq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_EMIT
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o    = (state_q == S_IDLE);
  assign ctrl_o.accept = in_valid_i && in_ready_o;
  assign ctrl_o.exec   = (state_q == S_EXEC);
  assign ctrl_o.load   = (state_q == S_EMIT) && stat_i.out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (ctrl_o.accept) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (ctrl_o.load && !stat_i.dump_more) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ src/deq_datapath.sv @@
// ----------------------------------------------------------------------------
// Double-ended queue datapath
// Circular entry store, front pointer, count, orientation flag, dump walker
// and the result register.
// ----------------------------------------------------------------------------
module deq_datapath #(
  parameter int unsigned Depth = deq_pkg::DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  deq_pkg::deq_cmd_t   ctrl_i,
  output deq_pkg::deq_stat_t  stat_o,
  input  logic [2:0]          cmd_i,
  input  logic signed [31:0]  value_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic signed [31:0]  data_out_o,
  output logic [1:0]          status_o,
  output logic [4:0]          occupancy_o,
  output logic                last_o
);
  import deq_pkg::*;

  localparam int unsigned PW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  typedef logic [PW-1:0] ptr_t;
  typedef logic [CW-1:0] cnt_t;
  typedef enum logic [1:0] {
    RES_ZERO,
    RES_VALUE,
    RES_MEM
  } res_sel_e;

  function automatic ptr_t ptr_inc(ptr_t p);
    return (p == ptr_t'(Depth - 1)) ? '0 : p + ptr_t'(1);
  endfunction

  function automatic ptr_t ptr_dec(ptr_t p);
    return (p == '0) ? ptr_t'(Depth - 1) : p - ptr_t'(1);
  endfunction

  function automatic ptr_t ptr_add(ptr_t p, cnt_t c);
    logic [CW:0] s;
    s = (CW + 1)'(p) + (CW + 1)'(c);
    if (s >= (CW + 1)'(Depth)) s = s - (CW + 1)'(Depth);
    return s[PW-1:0];
  endfunction

  logic [2:0]         cmd_q;
  logic signed [31:0] value_q;
  logic [31:0]        mem_q [Depth];
  logic [31:0]        rdata_q;
  ptr_t               front_q, front_d;
  cnt_t               count_q, count_d;
  logic               rev_q, rev_d;
  logic               dump_q, dump_d;
  ptr_t               dump_ptr_q, dump_ptr_d;
  cnt_t               dump_rem_q, dump_rem_d;
  logic               dump_low_q, dump_low_d;
  res_sel_e           res_sel_q, res_sel_d;
  logic [1:0]         res_status_q, res_status_d;
  logic               out_valid_q;
  logic signed [31:0] data_q;
  logic [1:0]         status_q;
  logic [4:0]         occ_q;
  logic               last_q;

  logic        wr_en, rd_en;
  ptr_t        wr_addr, rd_addr;
  ptr_t        back_slot, tail_slot;
  logic        empty, full, at_low, dump_low_w, more;
  logic [31:0] occ_ext;

  assign empty      = (count_q == '0);
  assign full       = (count_q == cnt_t'(Depth));
  assign back_slot  = ptr_add(front_q, count_q - cnt_t'(1));
  assign tail_slot  = ptr_add(front_q, count_q);
  assign at_low     = ((cmd_q == CMD_PUSH_FRONT) || (cmd_q == CMD_POP_FRONT)) != rev_q;
  assign dump_low_w = (cmd_q == CMD_DUMP_FWD) != rev_q;
  assign more       = dump_q && (dump_rem_q != '0);
  assign occ_ext    = 32'(count_q);

  assign stat_o.out_free  = !out_valid_q || out_ready_i;
  assign stat_o.dump_more = more;

  always_comb begin
    front_d      = front_q;
    count_d      = count_q;
    rev_d        = rev_q;
    wr_en        = 1'b0;
    wr_addr      = tail_slot;
    rd_en        = 1'b0;
    rd_addr      = front_q;
    res_sel_d    = res_sel_q;
    res_status_d = res_status_q;
    dump_d       = dump_q;
    dump_ptr_d   = dump_ptr_q;
    dump_rem_d   = dump_rem_q;
    dump_low_d   = dump_low_q;
    if (ctrl_i.exec) begin
      res_sel_d    = RES_ZERO;
      res_status_d = ST_OK;
      dump_d       = 1'b0;
      unique case (cmd_q)
        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
          res_sel_d = RES_VALUE;
          if (full) begin
            res_status_d = ST_FULL;
          end else begin
            wr_en   = 1'b1;
            count_d = count_q + cnt_t'(1);
            if (at_low) begin
              front_d = ptr_dec(front_q);
              wr_addr = ptr_dec(front_q);
            end
          end
        end
        CMD_POP_FRONT, CMD_POP_BACK: begin
          if (empty) begin
            res_status_d = ST_EMPTY;
          end else begin
            res_sel_d = RES_MEM;
            rd_en     = 1'b1;
            count_d   = count_q - cnt_t'(1);
            if (at_low) begin
              front_d = ptr_inc(front_q);
            end else begin
              rd_addr = back_slot;
            end
          end
        end
        CMD_REVERSE: begin
          if (empty) res_status_d = ST_EMPTY;
          else rev_d = !rev_q;
        end
        CMD_DUMP_FWD, CMD_DUMP_BWD: begin
          if (empty) begin
            res_status_d = ST_EMPTY;
          end else begin
            res_sel_d  = RES_MEM;
            dump_d     = 1'b1;
            rd_en      = 1'b1;
            rd_addr    = dump_low_w ? front_q : back_slot;
            dump_ptr_d = dump_low_w ? front_q : back_slot;
            dump_rem_d = count_q - cnt_t'(1);
            dump_low_d = dump_low_w;
          end
        end
        default: ;
      endcase
    end else if (ctrl_i.load && more) begin
      rd_en      = 1'b1;
      rd_addr    = dump_low_q ? ptr_inc(dump_ptr_q) : ptr_dec(dump_ptr_q);
      dump_ptr_d = dump_low_q ? ptr_inc(dump_ptr_q) : ptr_dec(dump_ptr_q);
      dump_rem_d = dump_rem_q - cnt_t'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= value_q;
    if (rd_en) rdata_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      cmd_q   <= cmd_i;
      value_q <= value_i;
    end
    dump_ptr_q   <= dump_ptr_d;
    dump_rem_q   <= dump_rem_d;
    dump_low_q   <= dump_low_d;
    res_sel_q    <= res_sel_d;
    res_status_q <= res_status_d;
    if (ctrl_i.load) begin
      unique case (res_sel_q)
        RES_MEM:   data_q <= rdata_q;
        RES_VALUE: data_q <= value_q;
        default:   data_q <= '0;
      endcase
      status_q <= res_status_q;
      occ_q    <= occ_ext[4:0];
      last_q   <= !more;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      count_q     <= '0;
      rev_q       <= 1'b0;
      dump_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      front_q <= front_d;
      count_q <= count_d;
      rev_q   <= rev_d;
      dump_q  <= dump_d;
      if (ctrl_i.load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign data_out_o  = data_q;
  assign status_o    = status_q;
  assign occupancy_o = occ_q;
  assign last_o      = last_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cnt_t'(Depth))
    else $error("entry count exceeds depth");

  a_front_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_q <= ptr_t'(Depth - 1))
    else $error("front pointer out of range");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.load |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over a pending beat");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_en && rd_en))
    else $error("store read and written in the same cycle");
`endif

endmodule

@@ src/double_ended_queue_with_reverse_core.sv @@
// ----------------------------------------------------------------------------
// Double-ended queue with reverse
// Bounded deque of signed 32-bit words with push, pop, reverse and dump.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o) carries one command beat: cmd_i and
// value_i. Output channel (out_valid_o/out_ready_i) carries result beats:
// data_out_o, status_o, occupancy_o and last_o, which marks the final beat
// of a command.
// One command is in flight at a time. A single-result command goes from
// accept to its result beat through latch, execute with store access and
// load of the result register, held off while a beat waits. The next command
// is taken the cycle after that load. A dump of n entries yields n beats,
// one per cycle while the receiver takes them, paced by the single read port
// of the entry store. The result register parts the two channels: a beat
// waiting for the receiver holds, the next command may be accepted
// meanwhile, and its result waits until the register is taken.
// Reset clears the front pointer, count, orientation flag and result valid;
// the queue is empty and ready on the first cycle after reset.
// ----------------------------------------------------------------------------
module double_ended_queue_with_reverse_core #(
  parameter int unsigned Depth = deq_pkg::DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         cmd_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] data_out_o,
  output logic [1:0]         status_o,
  output logic [4:0]         occupancy_o,
  output logic               last_o
);
  import deq_pkg::*;

  deq_cmd_t  ctrl;
  deq_stat_t stat;

  deq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  deq_datapath #(
    .Depth (Depth)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .cmd_i       (cmd_i),
    .value_i     (value_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .data_out_o  (data_out_o),
    .status_o    (status_o),
    .occupancy_o (occupancy_o),
    .last_o      (last_o)
  );

endmodule

@@ bench/double_ended_queue_with_reverse_core_test.sv @@
// ----------------------------------------------------------------------------
// Double-ended queue with reverse - block test
// Drives command beats through a stalling valid/ready source. A deque
// predictor in the monitor tracks the store, front slot, count and
// orientation, and checks every result beat field by field, in order.
// ----------------------------------------------------------------------------
module double_ended_queue_with_reverse_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import deq_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam logic [2:0] CMD_UNUSED = 3'd7;
  localparam int STALL_LEN = 200;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] value;
  } deq_item_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic [1:0]         status;
    logic [4:0]         occ;
    logic               last;
  } deq_beat_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [2:0]         cmd_i = '0;
  logic signed [31:0] value_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] data_out_o;
  logic [1:0]         status_o;
  logic [4:0]         occupancy_o;
  logic               last_o;

  deq_item_t cmd_q[$];
  deq_beat_t want_q[$];

  int  errors = 0;
  int  in_gap_max = 0;
  int  out_gap_max = 0;
  int  in_gap = 0;
  int  out_wait = 0;
  int  rx_stall_ask = 0;
  int  rx_stall_seen = 0;
  int  rx_stall_left = 0;
  bit  in_taken = 1'b0;
  bit  out_taken = 1'b0;

  logic signed [31:0] q_store [DEPTH];
  int                 q_front = 0;
  int                 q_count = 0;
  bit                 q_rev = 1'b0;

  double_ended_queue_with_reverse_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .data_out_o  (data_out_o),
    .status_o    (status_o),
    .occupancy_o (occupancy_o),
    .last_o      (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void add_beat(logic signed [31:0] data, logic [1:0] st, logic fin);
    deq_beat_t b;
    b.data   = data;
    b.status = st;
    b.occ    = q_count[4:0];
    b.last   = fin;
    want_q.push_back(b);
  endfunction

  function automatic void deque_apply(logic [2:0] cmd, logic signed [31:0] value);
    bit                 at_low;
    int                 off;
    logic signed [31:0] word;
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (q_count >= DEPTH) begin
          add_beat(value, ST_FULL, 1'b1);
        end else begin
          at_low = (cmd == CMD_PUSH_FRONT) != q_rev;
          if (at_low) begin
            q_front = (q_front + DEPTH - 1) % DEPTH;
            q_store[q_front] = value;
          end else begin
            q_store[(q_front + q_count) % DEPTH] = value;
          end
          q_count++;
          add_beat(value, ST_OK, 1'b1);
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (q_count == 0) begin
          add_beat('0, ST_EMPTY, 1'b1);
        end else begin
          at_low = (cmd == CMD_POP_FRONT) != q_rev;
          if (at_low) begin
            word = q_store[q_front];
            q_front = (q_front + 1) % DEPTH;
          end else begin
            word = q_store[(q_front + q_count - 1) % DEPTH];
          end
          q_count--;
          add_beat(word, ST_OK, 1'b1);
        end
      end
      CMD_REVERSE: begin
        if (q_count == 0) begin
          add_beat('0, ST_EMPTY, 1'b1);
        end else begin
          q_rev = !q_rev;
          add_beat('0, ST_OK, 1'b1);
        end
      end
      CMD_DUMP_FWD, CMD_DUMP_BWD: begin
        if (q_count == 0) begin
          add_beat('0, ST_EMPTY, 1'b1);
        end else begin
          at_low = (cmd == CMD_DUMP_FWD) != q_rev;
          for (int i = 0; i < q_count; i++) begin
            off = at_low ? i : (q_count - 1 - i);
            add_beat(q_store[(q_front + off) % DEPTH], ST_OK, i == q_count - 1);
          end
        end
      end
      default: begin
        add_beat('0, ST_OK, 1'b1);
      end
    endcase
  endfunction

  task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin : monitor
    deq_beat_t w;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (want_q.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual data %h status %0d occ %0d last %0b",
                   $time, data_out_o, status_o, occupancy_o, last_o);
          errors++;
        end else begin
          w = want_q.pop_front();
          check_field("data_out", w.data, data_out_o);
          check_field("status", 32'(w.status), 32'(status_o));
          check_field("occupancy", 32'(w.occ), 32'(occupancy_o));
          check_field("last", 32'(w.last), 32'(last_o));
        end
      end
      if (in_valid_i && in_ready_o) begin
        deque_apply(cmd_i, value_i);
      end
      in_taken  <= in_valid_i && in_ready_o;
      out_taken <= out_valid_o && out_ready_i;
    end
  end

  always @(negedge clk_i) begin : drive_in
    deq_item_t cur;
    if (rst_ni) begin
      if (in_valid_i && !in_taken) begin
        // hold
      end else if (in_gap > 0) begin
        in_valid_i <= 1'b0;
        in_gap     <= in_gap - 1;
      end else if (cmd_q.size() > 0) begin
        cur = cmd_q.pop_front();
        cmd_i      <= cur.cmd;
        value_i    <= cur.value;
        in_valid_i <= 1'b1;
        in_gap     <= $urandom_range(0, in_gap_max);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin : drive_out
    int w;
    if (rst_ni) begin
      if (rx_stall_ask != rx_stall_seen) begin
        rx_stall_seen <= rx_stall_ask;
        rx_stall_left <= STALL_LEN;
        out_ready_i   <= 1'b0;
      end else if (rx_stall_left > 0) begin
        rx_stall_left <= rx_stall_left - 1;
        out_ready_i   <= 1'b0;
      end else if (out_taken) begin
        w = $urandom_range(0, out_gap_max);
        out_wait    <= w;
        out_ready_i <= (w == 0);
      end else if (out_wait > 0) begin
        out_wait    <= out_wait - 1;
        out_ready_i <= (out_wait == 1);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic queue_item(logic [2:0] cmd, logic signed [31:0] value);
    deq_item_t it;
    it.cmd   = cmd;
    it.value = value;
    cmd_q.push_back(it);
  endtask

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'sh0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  task automatic wait_drained();
    do
      @(posedge clk_i);
    while (cmd_q.size() != 0 || in_valid_i || want_q.size() != 0);
  endtask

  task automatic run_phase(int n, int push_pct, int gi, int go);
    logic [2:0] cmd;
    @(posedge clk_i);
    in_gap_max  = gi;
    out_gap_max = go;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < push_pct) begin
        cmd = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
      end else begin
        cmd = 3'($urandom_range(2, 7));
      end
      queue_item(cmd, rand_word());
    end
    wait_drained();
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    queue_item(CMD_POP_FRONT, 32'sh1);
    queue_item(CMD_POP_BACK, -32'sd1);
    queue_item(CMD_REVERSE, 32'sh0);
    queue_item(CMD_DUMP_FWD, 32'sh0);
    queue_item(CMD_DUMP_BWD, 32'sh0);
    queue_item(CMD_UNUSED, -32'sd1);
    queue_item(CMD_PUSH_FRONT, 32'sh7fffffff);
    queue_item(CMD_PUSH_BACK, 32'sh80000000);
    queue_item(CMD_PUSH_FRONT, 32'sh0);
    queue_item(CMD_PUSH_BACK, -32'sd1);
    queue_item(CMD_DUMP_FWD, 32'sh0);
    queue_item(CMD_DUMP_BWD, 32'sh0);
    queue_item(CMD_REVERSE, 32'sh0);
    queue_item(CMD_DUMP_FWD, 32'sh0);
    queue_item(CMD_PUSH_FRONT, 32'sh12345678);
    queue_item(CMD_POP_BACK, 32'sh0);
    queue_item(CMD_POP_FRONT, 32'sh0);
    queue_item(CMD_UNUSED, 32'sh0);
    queue_item(CMD_REVERSE, 32'sh0);
    queue_item(CMD_POP_FRONT, 32'sh0);
    queue_item(CMD_POP_BACK, 32'sh0);
    queue_item(CMD_DUMP_BWD, 32'sh0);
    wait_drained();

    run_phase(28, 90, 0, 0);
    run_phase(28, 40, 8, 8);
    run_phase(28, 95, 3, 0);
    run_phase(28, 20, 8, 2);
    rx_stall_ask = rx_stall_ask + 1;
    run_phase(28, 70, 0, 0);
    run_phase(28, 50, 8, 8);
    run_phase(28, 85, 0, 8);
    run_phase(28, 30, 2, 2);
    run_phase(28, 90, 8, 0);
    run_phase(28, 15, 0, 0);

    repeat (20) @(negedge clk_i);
    if (errors == 0 && want_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      if (want_q.size() != 0) begin
        $display("%0t: %0d expected beats never arrived", $time, want_q.size());
      end
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("%0t: timeout", $time);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
